[design/plsl_pkg.sv]
// ============================================================================
// plsl_pkg - shared types and constants of the sensor linearizer
// Field widths, register reset values, register indexes and the payload
// structures that travel between the pipeline stages.
// ============================================================================
package plsl_pkg;

  // Field widths fixed by the register map and the result format.
  localparam int BP_BITS       = 12;
  localparam int STEP_BITS     = 14;
  localparam int POS_BITS      = 16;
  localparam int CFG_IDX_BITS  = 3;
  localparam int CFG_DATA_BITS = 16;
  localparam int NUM_BP        = 5;

  // Default sample width.
  localparam int SAMPLE_BITS_DEF = 12;

  // Datapath widths. The offset into a segment and the segment width both
  // stay below the largest breakpoint, so they fit the breakpoint width.
  localparam int DIFF_BITS = BP_BITS;
  localparam int SPAN_BITS = BP_BITS;
  localparam int PROD_BITS = DIFF_BITS + STEP_BITS;
  localparam int QUOT_BITS = STEP_BITS;

  // The divider resolves this many quotient bits per pipeline stage.
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES = (QUOT_BITS + DIV_STEPS_PER_STAGE - 1) / DIV_STEPS_PER_STAGE;

  // Register reset values.
  localparam logic [BP_BITS-1:0]   BREAK_ZERO_RST  = 12'd640;
  localparam logic [BP_BITS-1:0]   BREAK_ONE_RST   = 12'd794;
  localparam logic [BP_BITS-1:0]   BREAK_TWO_RST   = 12'd1110;
  localparam logic [BP_BITS-1:0]   BREAK_THREE_RST = 12'd2479;
  localparam logic [BP_BITS-1:0]   BREAK_FOUR_RST  = 12'd4092;
  localparam logic [STEP_BITS-1:0] OUTPUT_STEP_RST = 14'd500;

  // Register indexes on the configuration channel.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_BREAK_ZERO  = 3'd0,
    REG_BREAK_ONE   = 3'd1,
    REG_BREAK_TWO   = 3'd2,
    REG_BREAK_THREE = 3'd3,
    REG_BREAK_FOUR  = 3'd4,
    REG_OUTPUT_STEP = 3'd5
  } cfg_idx_e;

  // Current register contents.
  typedef struct packed {
    logic [NUM_BP-1:0][BP_BITS-1:0] bp;
    logic [STEP_BITS-1:0]           step;
  } cfg_t;

  // Result of the segment search.
  typedef struct packed {
    logic [DIFF_BITS-1:0] diff;
    logic [SPAN_BITS-1:0] span;
    logic [1:0]           seg;
    logic                 sat;
  } cls_t;

  // Divider state: partial remainder, a shift register that gives up
  // dividend bits at the top and takes quotient bits at the bottom, the
  // divisor and the segment base value.
  typedef struct packed {
    logic [SPAN_BITS-1:0] span;
    logic [SPAN_BITS-1:0] rem;
    logic [QUOT_BITS-1:0] lq;
    logic [POS_BITS-1:0]  base;
  } div_t;

endpackage

[design/plsl_cfg.sv]
// ============================================================================
// plsl_cfg - configuration registers
// Holds the five breakpoints and the output step. Writes are taken in every
// cycle; an index outside the register map is ignored.
// ============================================================================
module plsl_cfg import plsl_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i,
  output cfg_t                     cfg_o
);

  // Written breakpoints keep no bits above the sample width.
  localparam int BpKeep = (SAMPLE_BITS < BP_BITS) ? SAMPLE_BITS : BP_BITS;
  localparam logic [BP_BITS-1:0] BpMask = {BP_BITS{1'b1}} >> (BP_BITS - BpKeep);

  cfg_t                 cfg_q, cfg_d;
  logic [BP_BITS-1:0]   bp_wr;

  assign cfg_ready_o = 1'b1;
  assign bp_wr       = cfg_data_i[BP_BITS-1:0] & BpMask;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_BREAK_ZERO:  cfg_d.bp[0] = bp_wr;
        REG_BREAK_ONE:   cfg_d.bp[1] = bp_wr;
        REG_BREAK_TWO:   cfg_d.bp[2] = bp_wr;
        REG_BREAK_THREE: cfg_d.bp[3] = bp_wr;
        REG_BREAK_FOUR:  cfg_d.bp[4] = bp_wr;
        REG_OUTPUT_STEP: cfg_d.step  = cfg_data_i[STEP_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Reset values are loaded as they are, whatever the sample width.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.bp[0] <= BREAK_ZERO_RST;
      cfg_q.bp[1] <= BREAK_ONE_RST;
      cfg_q.bp[2] <= BREAK_TWO_RST;
      cfg_q.bp[3] <= BREAK_THREE_RST;
      cfg_q.bp[4] <= BREAK_FOUR_RST;
      cfg_q.step  <= OUTPUT_STEP_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

[design/plsl_classify.sv]
// ============================================================================
// plsl_classify - segment search stage
// Compares the sample against the breakpoints in priority order and
// registers the offset into the chosen segment, its width, its number and the saturation flag.
// ============================================================================
module plsl_classify import plsl_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cfg_t                   cfg_i,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic [SAMPLE_BITS-1:0] sample_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output cls_t                   cls_o
);

  localparam int CmpW = (SAMPLE_BITS > BP_BITS) ? SAMPLE_BITS : BP_BITS;

  logic [CmpW-1:0] s_ext, lo_ext, hi_ext;
  logic [CmpW-1:0] b_ext [NUM_BP];
  cls_t            cls_d, cls_q;
  logic            valid_q;

  always_comb begin
    for (int i = 0; i < NUM_BP; i++) begin
      b_ext[i] = CmpW'(cfg_i.bp[i]);
    end
  end

  assign s_ext = CmpW'(sample_i);

  // Priority compare; the clamped cases pass a zero offset over a unit span
  // so the divider yields zero.
  always_comb begin
    cls_d.sat = 1'b0;
    cls_d.seg = 2'd0;
    lo_ext    = s_ext;
    hi_ext    = s_ext + CmpW'(1);
    if (s_ext <= b_ext[0]) begin
      cls_d.seg = 2'd0;
    end else if (s_ext >= b_ext[4]) begin
      cls_d.sat = 1'b1;
    end else if (s_ext < b_ext[1]) begin
      cls_d.seg = 2'd0;
      lo_ext    = b_ext[0];
      hi_ext    = b_ext[1];
    end else if (s_ext < b_ext[2]) begin
      cls_d.seg = 2'd1;
      lo_ext    = b_ext[1];
      hi_ext    = b_ext[2];
    end else if (s_ext < b_ext[3]) begin
      cls_d.seg = 2'd2;
      lo_ext    = b_ext[2];
      hi_ext    = b_ext[3];
    end else begin
      cls_d.seg = 2'd3;
      lo_ext    = b_ext[3];
      hi_ext    = b_ext[4];
    end
    cls_d.diff = DIFF_BITS'(s_ext - lo_ext);
    cls_d.span = SPAN_BITS'(hi_ext - lo_ext);
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      cls_q <= cls_d;
    end
  end

  assign valid_o = valid_q;
  assign cls_o   = cls_q;

endmodule

[design/plsl_mul.sv]
// ============================================================================
// plsl_mul - product stage
// Multiplies the segment offset by the output step and forms the segment
// base value, then seeds the divider state.
// ============================================================================
module plsl_mul import plsl_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  cfg_t cfg_i,
  input  logic valid_i,
  output logic ready_o,
  input  cls_t cls_i,
  output logic valid_o,
  input  logic ready_i,
  output div_t div_o
);

  logic [PROD_BITS-1:0] prod;
  logic [POS_BITS-1:0]  step_ext;
  div_t                 div_d, div_q;
  logic                 valid_q;

  assign step_ext = POS_BITS'(cfg_i.step);
  assign prod     = PROD_BITS'(cls_i.diff) * PROD_BITS'(cfg_i.step);

  // Base value: segment number times step, or four steps when saturated.
  always_comb begin
    div_d.span = cls_i.span;
    div_d.rem  = prod[PROD_BITS-1 -: SPAN_BITS];
    div_d.lq   = prod[QUOT_BITS-1:0];
    if (cls_i.sat) begin
      div_d.base = step_ext << 2;
    end else begin
      case (cls_i.seg)
        2'd0:    div_d.base = '0;
        2'd1:    div_d.base = step_ext;
        2'd2:    div_d.base = step_ext << 1;
        2'd3:    div_d.base = (step_ext << 1) + step_ext;
        default: div_d.base = '0;
      endcase
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

[design/plsl_div_stage.sv]
// ============================================================================
// plsl_div_stage - one stage of the restoring divider
// Resolves STEPS quotient bits per stage. The remainder stays below the
// divisor, so each trial subtract works on one bit more than the divisor.
// ============================================================================
module plsl_div_stage import plsl_pkg::*; #(
  parameter int STEPS = DIV_STEPS_PER_STAGE
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic valid_i,
  output logic ready_o,
  input  div_t div_i,
  output logic valid_o,
  input  logic ready_i,
  output div_t div_o
);

  div_t div_d, div_q;
  logic valid_q;

  // Shift-and-subtract steps.
  always_comb begin
    logic [SPAN_BITS:0] trial;
    div_d = div_i;
    for (int i = 0; i < STEPS; i++) begin
      trial = {div_d.rem, div_d.lq[QUOT_BITS-1]};
      if (trial >= {1'b0, div_d.span}) begin
        trial    = trial - {1'b0, div_d.span};
        div_d.lq = {div_d.lq[QUOT_BITS-2:0], 1'b1};
      end else begin
        div_d.lq = {div_d.lq[QUOT_BITS-2:0], 1'b0};
      end
      div_d.rem = trial[SPAN_BITS-1:0];
    end
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (valid_i && ready_o) begin
      div_q <= div_d;
    end
  end

  assign valid_o = valid_q;
  assign div_o   = div_q;

endmodule

[design/piecewise_linear_sensor_linearizer_top.sv]
// ============================================================================
// piecewise_linear_sensor_linearizer_top - four-segment sensor linearizer
// Maps each converter sample through four straight segments between five
// programmable breakpoints and returns the interpolated position.
// ============================================================================
//
//  Channel   Direction  Signals                          Content
//  s_axis    in         s_axis_tvalid/tready/tdata        adc_sample
//  m_axis    out        m_axis_tvalid/tready/tdata        position
//  cfg       in         cfg_valid_i/ready_o/index_i/data_i register writes
//
//  From input transfer to result a sample passes the segment search,
//  multiply, 7 divider stages of 2 quotient bits each, and the final add.
//  One sample is taken per cycle while the output is not stalled.
//  Reset loads the register defaults and empties the pipeline.
//  Every stage has its own ready, so a stalled output fills bubbles first.
//
module piecewise_linear_sensor_linearizer_top import plsl_pkg::*; #(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int InDataBits = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  // Input samples.
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [InDataBits-1:0]    s_axis_tdata,  // [SAMPLE_BITS-1:0] adc_sample
  // Linearized positions.
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [POS_BITS-1:0]      m_axis_tdata,  // [15:0] position
  // Register writes.
  input  logic                     cfg_valid_i,
  output logic                     cfg_ready_o,
  input  logic [CFG_IDX_BITS-1:0]  cfg_index_i,
  input  logic [CFG_DATA_BITS-1:0] cfg_data_i
);

  cfg_t cfg;
  cls_t cls;
  logic cls_valid, cls_ready;
  logic mul_valid, mul_ready;
  div_t mul_div;

  div_t div_pl    [DIV_STAGES+1];
  logic div_valid [DIV_STAGES+1];
  logic div_ready [DIV_STAGES+1];

  logic                out_valid_q;
  logic [POS_BITS-1:0] pos_q, pos_d;
  logic                out_ready;

  // Configuration registers.
  plsl_cfg #(.SAMPLE_BITS(SAMPLE_BITS)) u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Segment search.
  plsl_classify #(.SAMPLE_BITS(SAMPLE_BITS)) u_classify (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .valid_i  (s_axis_tvalid),
    .ready_o  (s_axis_tready),
    .sample_i (s_axis_tdata[SAMPLE_BITS-1:0]),
    .valid_o  (cls_valid),
    .ready_i  (cls_ready),
    .cls_o    (cls)
  );

  // Product and base value.
  plsl_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg),
    .valid_i (cls_valid),
    .ready_o (cls_ready),
    .cls_i   (cls),
    .valid_o (mul_valid),
    .ready_i (mul_ready),
    .div_o   (mul_div)
  );

  assign div_pl[0]    = mul_div;
  assign div_valid[0] = mul_valid;
  assign mul_ready    = div_ready[0];

  // Divider chain.
  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    plsl_div_stage #(.STEPS(DIV_STEPS_PER_STAGE)) u_div_stage (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (div_valid[g]),
      .ready_o (div_ready[g]),
      .div_i   (div_pl[g]),
      .valid_o (div_valid[g+1]),
      .ready_i (div_ready[g+1]),
      .div_o   (div_pl[g+1])
    );
  end

  assign div_ready[DIV_STAGES] = out_ready;

  // Output register: segment base plus the interpolated fraction.
  assign pos_d     = div_pl[DIV_STAGES].base + POS_BITS'(div_pl[DIV_STAGES].lq);
  assign out_ready = ~out_valid_q | m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_ready) begin
      out_valid_q <= div_valid[DIV_STAGES];
    end
  end

  always_ff @(posedge clk_i) begin
    if (div_valid[DIV_STAGES] && out_ready) begin
      pos_q <= pos_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = pos_q;

endmodule

[dv/piecewise_linear_sensor_linearizer_top_tb.sv]
`timescale 1ns / 1ps
// ============================================================================
// piecewise_linear_sensor_linearizer_top_tb - sensor linearizer regression
// Streams converter samples through the linearizer under several breakpoint
// and step settings, predicts each position in the bench and compares every
// output transfer in order. Sender bursts, receiver stalls and one long
// output hold-off exercise the pipeline handshakes.
// ============================================================================
module piecewise_linear_sensor_linearizer_top_tb;
  import plsl_pkg::*;

  localparam int SAMPLE_W     = SAMPLE_BITS_DEF;
  localparam int S_DATA_W     = ((SAMPLE_W + 7) / 8) * 8;
  localparam int PIPE_LATENCY = 10;
  localparam int IDLE_LIMIT   = 3000;
  localparam int HOLD_CYCLES  = 300;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MAX = '1;

  // Indexes outside the register map; writes to them must change nothing.
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_SIX   = 3'd6;
  localparam logic [CFG_IDX_BITS-1:0] REG_SPARE_SEVEN = 3'd7;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [S_DATA_W-1:0]      s_axis_tdata = '0;  // [11:0] adc_sample
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [POS_BITS-1:0]      m_axis_tdata;       // [15:0] position
  logic                     cfg_valid_i = 1'b0;
  logic                     cfg_ready_o;
  logic [CFG_IDX_BITS-1:0]  cfg_index_i = REG_BREAK_ZERO;
  logic [CFG_DATA_BITS-1:0] cfg_data_i = '0;

  piecewise_linear_sensor_linearizer_top DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Bench copy of the register file and the positions still owed.
  logic [BP_BITS-1:0]   brk [NUM_BP];
  logic [STEP_BITS-1:0] out_step;
  logic [POS_BITS-1:0]  expected_pos [$];
  int                   errors = 0;

  // Sender burst state.
  int burst_left  = 0;
  bit steady_send = 1'b0;

  // Receiver stall state; a hold-off is requested by bumping hold_requests.
  int hold_requests = 0;
  int hold_served   = 0;
  int hold_left     = 0;
  int rx_mode       = 0;
  int rx_mode_left  = 0;
  int rx_cycle      = 0;
  int idle_cycles   = 0;
  logic [POS_BITS-1:0] want_pos;

  // Expected position for one sample under the current registers.
  function automatic logic [POS_BITS-1:0] linearize(input logic [SAMPLE_W-1:0] s);
    int unsigned seg, lo, hi, pos;
    if (s <= brk[0]) begin
      pos = 0;
    end else if (s >= brk[4]) begin
      pos = 4 * out_step;
    end else begin
      if (s < brk[1]) seg = 0;
      else if (s < brk[2]) seg = 1;
      else if (s < brk[3]) seg = 2;
      else seg = 3;
      lo  = brk[seg];
      hi  = brk[seg+1];
      pos = seg * out_step;
      // The compare order guarantees hi > lo here; guard anyway.
      if (hi > lo) pos = pos + ((s - lo) * out_step) / (hi - lo);
    end
    return pos[POS_BITS-1:0];
  endfunction

  // Random sample: mostly uniform, some around the breakpoints and the ends.
  function automatic logic [SAMPLE_W-1:0] pick_sample();
    int v;
    case ($urandom_range(0, 9))
      6, 7: begin
        v = int'(brk[$urandom_range(0, NUM_BP - 1)]) + int'($urandom_range(0, 4)) - 2;
        if (v < 0) v = 0;
        if (v > int'(SAMPLE_MAX)) v = SAMPLE_MAX;
      end
      8: v = $urandom_range(0, 1) ? int'(SAMPLE_MAX) : 0;
      default: v = $urandom_range(0, SAMPLE_MAX);
    endcase
    return v[SAMPLE_W-1:0];
  endfunction

  // One sample transfer; the sender pauses between bursts unless held steady.
  task automatic send_sample(input logic [SAMPLE_W-1:0] s);
    int gap;
    if (!steady_send && burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    if (burst_left > 0) burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_DATA_W'(s);
    do @(posedge clk_i); while (!s_axis_tready);
    expected_pos.push_back(linearize(s));
  endtask

  // Stop offering samples and let the pipeline empty completely.
  task automatic drain_pipe();
    s_axis_tvalid <= 1'b0;
    while (expected_pos.size() != 0) @(posedge clk_i);
    repeat (PIPE_LATENCY + 2) @(posedge clk_i);
  endtask

  // One register transfer; valid is left high for a following write.
  task automatic write_reg(input logic [CFG_IDX_BITS-1:0] idx,
                           input logic [CFG_DATA_BITS-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      REG_BREAK_ZERO:  brk[0]   = data[BP_BITS-1:0];
      REG_BREAK_ONE:   brk[1]   = data[BP_BITS-1:0];
      REG_BREAK_TWO:   brk[2]   = data[BP_BITS-1:0];
      REG_BREAK_THREE: brk[3]   = data[BP_BITS-1:0];
      REG_BREAK_FOUR:  brk[4]   = data[BP_BITS-1:0];
      REG_OUTPUT_STEP: out_step = data[STEP_BITS-1:0];
      default: ;
    endcase
  endtask

  // Writes all six registers while idle, optionally also the spare indexes.
  task automatic apply_config(input logic [CFG_DATA_BITS-1:0] b0, b1, b2, b3, b4, step,
                              input bit spare);
    drain_pipe();
    write_reg(REG_BREAK_ZERO, b0);
    write_reg(REG_BREAK_ONE, b1);
    write_reg(REG_BREAK_TWO, b2);
    write_reg(REG_BREAK_THREE, b3);
    write_reg(REG_BREAK_FOUR, b4);
    write_reg(REG_OUTPUT_STEP, step);
    if (spare) begin
      write_reg(REG_SPARE_SIX, CFG_DATA_BITS'($urandom));
      write_reg(REG_SPARE_SEVEN, CFG_DATA_BITS'($urandom));
    end
    cfg_valid_i <= 1'b0;
  endtask

  // Random setting: ascending, with ties, unordered, narrow or extreme.
  task automatic random_config();
    logic [CFG_DATA_BITS-1:0] b [NUM_BP];
    logic [CFG_DATA_BITS-1:0] step;
    int kind, prev, room;
    kind = $urandom_range(0, 9);
    prev = $urandom_range(0, 1200);
    for (int i = 0; i < NUM_BP; i++) begin
      case (kind)
        6: begin
          if (i > 0 && $urandom_range(0, 1)) prev = prev;
          else prev = prev + $urandom_range(0, (int'(SAMPLE_MAX) - prev) / 3);
        end
        7: prev = $urandom_range(0, SAMPLE_MAX);
        8: prev = (i == 0) ? $urandom_range(0, SAMPLE_MAX - 20) : prev + $urandom_range(0, 3);
        9: prev = $urandom_range(0, 1) ? int'(SAMPLE_MAX) : 0;
        default: begin
          room = (int'(SAMPLE_MAX) - prev) / (NUM_BP - i);
          if (i > 0) prev = prev + $urandom_range(1, (room > 1) ? room : 1);
          if (prev > int'(SAMPLE_MAX)) prev = SAMPLE_MAX;
        end
      endcase
      // Bits above the register width are random and must be ignored.
      b[i] = {4'($urandom), prev[BP_BITS-1:0]};
    end
    case ($urandom_range(0, 7))
      0: step = '0;
      1: step = {2'($urandom), 14'h3fff};
      2: step = 16'd1;
      default: step = 16'($urandom);
    endcase
    apply_config(b[0], b[1], b[2], b[3], b[4], step, $urandom_range(0, 3) == 0);
  endtask

  // Receiver: check each output transfer, then pick this cycle's ready.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_pos.size() == 0) begin
        $display("%0t: unexpected position, expected none, actual %0d", $time,
                 m_axis_tdata);
        errors++;
      end else begin
        want_pos = expected_pos.pop_front();
        if (m_axis_tdata !== want_pos) begin
          $display("%0t: position mismatch, expected %0d, actual %0d", $time,
                   want_pos, m_axis_tdata);
          errors++;
        end
      end
    end
    rx_cycle++;
    if (hold_served != hold_requests) begin
      hold_served = hold_requests;
      hold_left   = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_axis_tready <= 1'b0;
    end else begin
      if (rx_mode_left == 0) begin
        rx_mode      = $urandom_range(0, 3);
        rx_mode_left = $urandom_range(20, 150);
      end
      rx_mode_left--;
      case (rx_mode)
        0: m_axis_tready <= 1'b1;
        1: m_axis_tready <= ($urandom_range(0, 3) != 0);
        2: m_axis_tready <= ($urandom_range(0, 3) == 0);
        default: m_axis_tready <= (rx_cycle % 5 != 0);
      endcase
    end
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  // Reset values: every segment edge, both ends and the saturation point.
  task automatic test_reset_defaults();
    send_sample(12'd0);
    send_sample(12'd640);
    send_sample(12'd641);
    send_sample(12'd793);
    send_sample(12'd794);
    send_sample(12'd1110);
    send_sample(12'd2478);
    send_sample(12'd2479);
    send_sample(12'd4091);
    send_sample(12'd4092);
    send_sample(SAMPLE_MAX);
  endtask

  // Tightest possible first three segments and the largest step.
  task automatic test_extreme_breakpoints();
    apply_config(16'd0, 16'd1, 16'd2, 16'd3, 16'd4095, 16'h3fff, 1'b0);
    send_sample(12'd0);
    send_sample(12'd1);
    send_sample(12'd2);
    send_sample(12'd3);
    send_sample(12'd4094);
    send_sample(SAMPLE_MAX);
  endtask

  // Data bits above each register width, plus writes to unmapped indexes.
  task automatic test_masked_and_spare_writes();
    apply_config(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 1'b1);
    send_sample(12'd4094);
    send_sample(SAMPLE_MAX);
  endtask

  // A zero step gives zero everywhere.
  task automatic test_zero_step();
    apply_config(16'd640, 16'd794, 16'd1110, 16'd2479, 16'd4092, 16'd0, 1'b0);
    send_sample(12'd700);
    send_sample(12'd3000);
  endtask

  // Breakpoints that are not ascending are used as they are.
  task automatic test_unordered_breakpoints();
    apply_config(16'd300, 16'd3000, 16'd1000, 16'd2000, 16'd3500, 16'd9999, 1'b0);
    send_sample(12'd2500);
    send_sample(12'd3200);
  endtask

  task automatic test_random_configs();
    for (int phase = 0; phase < 12; phase++) begin
      random_config();
      repeat ($urandom_range(90, 150)) send_sample(pick_sample());
    end
  endtask

  // Output held off for a long stretch while samples keep coming.
  task automatic test_output_hold_off();
    random_config();
    steady_send = 1'b1;
    hold_requests++;
    repeat (120) send_sample(pick_sample());
    steady_send = 1'b0;
  endtask

  initial begin
    brk[0]   = BREAK_ZERO_RST;
    brk[1]   = BREAK_ONE_RST;
    brk[2]   = BREAK_TWO_RST;
    brk[3]   = BREAK_THREE_RST;
    brk[4]   = BREAK_FOUR_RST;
    out_step = OUTPUT_STEP_RST;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_defaults();
    test_extreme_breakpoints();
    test_masked_and_spare_writes();
    test_zero_step();
    test_unordered_breakpoints();
    test_random_configs();
    test_output_hold_off();
    drain_pipe();

    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
